### sv/scb_pkg.sv
package scb_pkg;

   localparam int MAX_CELLS_DEF      = 4096;
   localparam int SLOTS_PER_CELL_DEF = 16;
   localparam int COORD_BITS_DEF     = 32;

   localparam int REQ_TDATA_W = 112;
   localparam int RSP_TDATA_W = 120;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WIDTH_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WIDTH_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WIDTH_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_DIMS   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_USED  = 3'd7;

   // response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_EMPTY   = 2'd3;

   typedef struct packed {
      logic       outside;
      logic [7:0] coord;
   } axis_res_type;

endpackage

### sv/spatial_cell_list_binner.sv
// Cell-list binner for 3-D points on a uniform grid. req_tuser selects the
// command: 0 inserts the point into the next free slot of its cell, 1 reads
// back one stored point with the fill count of its cell. Items are handled
// one at a time: an insert passes difference, multiply, range check, index
// multiply-add, count read and count and store update before its response
// is loaded, skipping count read and update when the point falls outside
// the grid; a read passes count read and store read, skipping the store
// read for an empty slot and both for a rejected cell; the block returns
// to idle for the next transaction once the response register is free.
// The response register lets an item be accepted while the previous
// response still waits. Cell fill counts live in a MAX_CELLS deep memory
// that is cleared after reset, one entry a cycle, so req_tready stays low
// until the clear ends; configuration writes are taken throughout. Points
// live in a second memory of MAX_CELLS*SLOTS_PER_CELL entries, cell-major.
module spatial_cell_list_binner #(
   parameter int MAX_CELLS      = scb_pkg::MAX_CELLS_DEF,
   parameter int SLOTS_PER_CELL = scb_pkg::SLOTS_PER_CELL_DEF,
   parameter int COORD_BITS     = scb_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x[31:0], pos_y[63:32], pos_z[95:64], read_cell[107:96], read_slot[111:108]
   input  logic [scb_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // cmd[0]
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_index[11:0], slot_index[15:12], cell_fill[20:16], out_x[52:21],
   // out_y[84:53], out_z[116:85], zero[119:117]
   output logic [scb_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status[1:0]
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_wen,
   input  logic [scb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import scb_pkg::*;

   localparam int CellW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int Depth  = MAX_CELLS * SLOTS_PER_CELL;
   localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW   = $clog2(SLOTS_PER_CELL + 1);
   localparam int CmpW   = (CntW > 4) ? CntW : 4;
   localparam int IdxW   = 25;
   localparam logic [AddrW-1:0] SlotsA = AddrW'(SLOTS_PER_CELL);
   localparam logic [CntW-1:0]  SlotsC = CntW'(SLOTS_PER_CELL);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DIFF  = 4'd2;
   localparam logic [3:0] ST_MUL   = 4'd3;
   localparam logic [3:0] ST_AXIS  = 4'd4;
   localparam logic [3:0] ST_INDEX = 4'd5;
   localparam logic [3:0] ST_LOOK  = 4'd6;
   localparam logic [3:0] ST_COUNT = 4'd7;
   localparam logic [3:0] ST_FETCH = 4'd8;
   localparam logic [3:0] ST_EMIT  = 4'd9;

   function automatic logic [RSP_TDATA_W-1:0] pack_rsp(
      input logic [11:0] cell_idx,
      input logic [3:0]  slot,
      input logic [4:0]  fill,
      input logic [31:0] x,
      input logic [31:0] y,
      input logic [31:0] z
   );
      pack_rsp = {3'b0, z, y, x, fill, slot, cell_idx};
   endfunction

   // configuration
   logic [31:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [31:0] inv_x_ff, inv_y_ff, inv_z_ff;
   logic [23:0] grid_dims_ff;
   logic [12:0] cells_used_ff;

   // control
   logic [3:0]       state_ff, state_in;
   logic [CellW-1:0] clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // transaction payload
   logic                   req_load;
   logic                   cmd_ff;
   logic [31:0]            pos_x_ff, pos_y_ff, pos_z_ff;
   logic [3:0]             rs_ff;
   logic [IdxW-1:0]        idx_ff, idx_in;
   logic                   outside_ff, outside_in;
   logic [7:0]             i_ff, i_in, k_ff, k_in;
   logic [15:0]            jnz_ff, jnz_in, nynz_ff, nynz_in;
   logic [1:0]             res_user_ff, res_user_in;
   logic [RSP_TDATA_W-1:0] res_data_ff, res_data_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;

   axis_res_type ax, ay, az;

   // memories
   logic [CntW-1:0]         cnt_mem [MAX_CELLS];
   logic [CntW-1:0]         cnt_rd_ff;
   logic                    cnt_re, cnt_we;
   logic [CellW-1:0]        cnt_wa;
   logic [CntW-1:0]         cnt_wd;
   logic [3*COORD_BITS-1:0] st_mem [Depth];
   logic [3*COORD_BITS-1:0] st_rd_ff;
   logic [3*COORD_BITS-1:0] st_wd;
   logic                    st_re, st_we;
   logic [AddrW-1:0]        st_addr;
   logic [AddrW-1:0]        slot_a;

   logic [CellW-1:0]        idx_cell;
   logic [IdxW-1:0]         limit;
   logic [CntW-1:0]         cnt_inc;
   logic                    cell_full;
   logic                    slot_empty;
   logic signed [COORD_BITS-1:0] rd_x_s, rd_y_s, rd_z_s;
   logic [11:0]             cell_out;

   scb_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .clock(clock), .pos(pos_x_ff), .origin(origin_x_ff), .inv_width(inv_x_ff),
      .count(grid_dims_ff[23:16]), .res(ax)
   );
   scb_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .clock(clock), .pos(pos_y_ff), .origin(origin_y_ff), .inv_width(inv_y_ff),
      .count(grid_dims_ff[15:8]), .res(ay)
   );
   scb_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
      .clock(clock), .pos(pos_z_ff), .origin(origin_z_ff), .inv_width(inv_z_ff),
      .count(grid_dims_ff[7:0]), .res(az)
   );

   assign limit = (IdxW'(cells_used_ff) < IdxW'(MAX_CELLS)) ? IdxW'(cells_used_ff)
                                                            : IdxW'(MAX_CELLS);
   assign idx_cell   = idx_ff[CellW-1:0];
   assign cell_out   = idx_ff[11:0];
   assign cnt_inc    = cnt_rd_ff + CntW'(1);
   assign cell_full  = (cnt_rd_ff >= SlotsC);
   assign slot_empty = (CmpW'(rs_ff) >= CmpW'(cnt_rd_ff));
   assign slot_a     = cmd_ff ? AddrW'(rs_ff) : AddrW'(cnt_rd_ff);
   assign st_addr    = AddrW'(idx_cell) * SlotsA + slot_a;
   assign st_wd      = {pos_z_ff[COORD_BITS-1:0], pos_y_ff[COORD_BITS-1:0],
                        pos_x_ff[COORD_BITS-1:0]};
   assign rd_x_s     = st_rd_ff[COORD_BITS-1:0];
   assign rd_y_s     = st_rd_ff[2*COORD_BITS-1:COORD_BITS];
   assign rd_z_s     = st_rd_ff[3*COORD_BITS-1:2*COORD_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      outside_in   = outside_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      jnz_in       = jnz_ff;
      nynz_in      = nynz_ff;
      res_user_in  = res_user_ff;
      res_data_in  = res_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_load     = 1'b0;
      cnt_re       = 1'b0;
      cnt_we       = 1'b0;
      cnt_wa       = idx_cell;
      cnt_wd       = cnt_inc;
      st_re        = 1'b0;
      st_we        = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cnt_we = 1'b1;
            cnt_wa = clr_ff;
            cnt_wd = '0;
            clr_in = clr_ff + CellW'(1);
            if (clr_ff == CellW'(MAX_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               req_load   = 1'b1;
               outside_in = 1'b0;
               idx_in     = IdxW'(req_tdata[107:96]);
               state_in   = req_tuser[0] ? ST_LOOK : ST_DIFF;
            end
         end
         ST_DIFF: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_AXIS;
         end
         ST_AXIS: begin
            outside_in = ax.outside || ay.outside || az.outside;
            i_in       = ax.coord;
            k_in       = az.coord;
            jnz_in     = 16'(ay.coord) * 16'(grid_dims_ff[7:0]);
            nynz_in    = 16'(grid_dims_ff[15:8]) * 16'(grid_dims_ff[7:0]);
            state_in   = ST_INDEX;
         end
         ST_INDEX: begin
            idx_in   = IdxW'(i_ff) * IdxW'(nynz_ff) + IdxW'(jnz_ff) + IdxW'(k_ff);
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (outside_ff || (idx_ff >= limit)) begin
               res_user_in = STATUS_OUTSIDE;
               res_data_in = cmd_ff ? pack_rsp(cell_out, rs_ff, 5'd0, 32'd0, 32'd0, 32'd0)
                                    : '0;
               state_in    = ST_EMIT;
            end else begin
               cnt_re   = 1'b1;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (!cmd_ff) begin
               if (cell_full) begin
                  res_user_in = STATUS_FULL;
                  res_data_in = pack_rsp(cell_out, 4'd0, 5'(cnt_rd_ff),
                                         32'd0, 32'd0, 32'd0);
               end else begin
                  cnt_we      = 1'b1;
                  st_we       = 1'b1;
                  res_user_in = STATUS_OK;
                  res_data_in = pack_rsp(cell_out, 4'(cnt_rd_ff), 5'(cnt_inc),
                                         32'd0, 32'd0, 32'd0);
               end
               state_in = ST_EMIT;
            end else if (slot_empty) begin
               res_user_in = STATUS_EMPTY;
               res_data_in = pack_rsp(cell_out, rs_ff, 5'(cnt_rd_ff), 32'd0, 32'd0, 32'd0);
               state_in    = ST_EMIT;
            end else begin
               st_re       = 1'b1;
               res_user_in = STATUS_OK;
               res_data_in = pack_rsp(cell_out, rs_ff, 5'(cnt_rd_ff), 32'd0, 32'd0, 32'd0);
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            res_data_in = pack_rsp(res_data_ff[11:0], res_data_ff[15:12], res_data_ff[20:16],
                                   32'(rd_x_s), 32'(rd_y_s), 32'(rd_z_s));
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_user_in  = res_user_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         origin_z_ff   <= '0;
         inv_x_ff      <= 32'd65536;
         inv_y_ff      <= 32'd65536;
         inv_z_ff      <= 32'd65536;
         grid_dims_ff  <= 24'd65793;
         cells_used_ff <= 13'd1;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_ORIGIN_X:    origin_x_ff   <= csr_wdata;
            CSR_ORIGIN_Y:    origin_y_ff   <= csr_wdata;
            CSR_ORIGIN_Z:    origin_z_ff   <= csr_wdata;
            CSR_INV_WIDTH_X: inv_x_ff      <= csr_wdata;
            CSR_INV_WIDTH_Y: inv_y_ff      <= csr_wdata;
            CSR_INV_WIDTH_Z: inv_z_ff      <= csr_wdata;
            CSR_GRID_DIMS:   grid_dims_ff  <= csr_wdata[23:0];
            CSR_CELLS_USED:  cells_used_ff <= csr_wdata[12:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         cmd_ff   <= req_tuser[0];
         pos_x_ff <= req_tdata[31:0];
         pos_y_ff <= req_tdata[63:32];
         pos_z_ff <= req_tdata[95:64];
         rs_ff    <= req_tdata[111:108];
      end
      idx_ff      <= idx_in;
      outside_ff  <= outside_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      jnz_ff      <= jnz_in;
      nynz_ff     <= nynz_in;
      res_user_ff <= res_user_in;
      res_data_ff <= res_data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // cell fill counts
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[idx_cell];
      end
   end

   // point store, x in the low bits
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_addr] <= st_wd;
      end
      if (st_re) begin
         st_rd_ff <= st_mem[st_addr];
      end
   end

   // one transaction in flight at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("transaction accepted while another is in flight");

   a_count_write: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (state_ff == ST_CLEAR || state_ff == ST_COUNT))
      else $error("fill count written outside clear or update");

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      st_we |-> (cnt_rd_ff < SlotsC))
      else $error("point stored into a full cell");

endmodule

### sv/scb_axis.sv
// One axis of the binning transform: d = pos - origin, then the integer
// part of d * inv_width (unsigned Q16.16 times Q16.16). Two register stages.
module scb_axis #(
   parameter int COORD_BITS = scb_pkg::COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic [31:0]          pos,
   input  logic [31:0]          origin,
   input  logic [31:0]          inv_width,
   input  logic [7:0]           count,
   output scb_pkg::axis_res_type res
);
   import scb_pkg::*;

   logic signed [32:0] pos_ext;
   logic signed [32:0] org_ext;
   logic signed [32:0] diff_in;
   logic signed [32:0] diff_ff;
   logic               neg_ff;
   logic [63:0]        prod_in;
   logic [63:0]        prod_ff;

   assign pos_ext = 33'(signed'(pos[COORD_BITS-1:0]));
   assign org_ext = 33'(signed'(origin));
   assign diff_in = pos_ext - org_ext;
   // a non-negative difference fits in 32 unsigned bits
   assign prod_in = diff_ff[31:0] * inv_width;

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      neg_ff  <= diff_ff[32];
      prod_ff <= prod_in;
   end

   assign res.outside = neg_ff || (prod_ff[63:32] >= {24'b0, count});
   assign res.coord   = prod_ff[39:32];

endmodule

### dv/tb_top.sv
module tb_top;
   import scb_pkg::*;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ   = 1'b1;
   localparam int   N_CELLS    = MAX_CELLS_DEF;
   localparam int   N_SLOTS    = SLOTS_PER_CELL_DEF;

   typedef struct {
      logic        cmd;
      logic [31:0] px, py, pz;
      logic [11:0] rc;
      logic [3:0]  rs;
   } bin_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [11:0] cell_idx;
      logic [3:0]  slot;
      logic [4:0]  fill;
      logic [31:0] ox, oy, oz;
   } bin_rsp_type;

   typedef struct {
      logic        cmd;
      logic [31:0] px, py, pz;
      logic [11:0] rc;
      logic [3:0]  rs;
      int          reps;
      bit          typed;
      logic [1:0]  st;
      logic [11:0] cell_idx;
      logic [3:0]  slot;
      logic [4:0]  fill;
      logic [31:0] ox, oy, oz;
   } dir_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   spatial_cell_list_binner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // shadow of the grid registers and the cell store
   logic [31:0] grid_org [3];
   logic [31:0] grid_inv [3];
   logic [23:0] grid_dims;
   logic [12:0] cells_used;
   logic [4:0]  fill_cnt [N_CELLS];
   logic [31:0] pt_x [N_CELLS*N_SLOTS];
   logic [31:0] pt_y [N_CELLS*N_SLOTS];
   logic [31:0] pt_z [N_CELLS*N_SLOTS];
   int unsigned last_cell = 0;

   bin_rsp_type pending_bins [$];
   int          errors     = 0;
   int          burst_left = 0;
   bit          hold_req   = 1'b0;

   function automatic int unsigned usable_cells();
      return (cells_used < N_CELLS) ? int'(cells_used) : N_CELLS;
   endfunction

   function automatic bit axis_bin(input logic [31:0] pos, input logic [31:0] org_v,
                                   input logic [31:0] inv_v, input int unsigned n,
                                   output int unsigned c);
      longint      d;
      logic [63:0] du;
      logic [63:0] prod;
      c = 0;
      d = longint'($signed(pos)) - longint'($signed(org_v));
      if (d < 0)
         return 1'b0;
      du   = d;
      prod = du * {32'd0, inv_v};
      if (prod[63:32] >= n)
         return 1'b0;
      c = prod[63:32];
      return 1'b1;
   endfunction

   function automatic bin_rsp_type predict_binning(input bin_req_type it);
      bin_rsp_type r;
      int unsigned nx, ny, nz, i, j, k, idx, cnt, a;
      bit          ix, iy, iz, in_grid;
      r = '{status: STATUS_OK, cell_idx: '0, slot: '0, fill: '0, ox: '0, oy: '0, oz: '0};
      if (it.cmd == CMD_INSERT) begin
         nx = grid_dims[23:16];
         ny = grid_dims[15:8];
         nz = grid_dims[7:0];
         ix = axis_bin(it.px, grid_org[0], grid_inv[0], nx, i);
         iy = axis_bin(it.py, grid_org[1], grid_inv[1], ny, j);
         iz = axis_bin(it.pz, grid_org[2], grid_inv[2], nz, k);
         in_grid = ix && iy && iz;
         idx = 0;
         if (in_grid) begin
            idx = k + j * nz + i * ny * nz;
            if (idx >= usable_cells())
               in_grid = 1'b0;
         end
         if (!in_grid) begin
            r.status = STATUS_OUTSIDE;
         end else begin
            cnt        = fill_cnt[idx];
            r.cell_idx = idx[11:0];
            last_cell  = idx;
            if (cnt >= N_SLOTS) begin
               r.status = STATUS_FULL;
               r.fill   = cnt[4:0];
            end else begin
               a = idx * N_SLOTS + cnt;
               pt_x[a] = it.px;
               pt_y[a] = it.py;
               pt_z[a] = it.pz;
               fill_cnt[idx] = 5'(cnt + 1);
               r.slot = cnt[3:0];
               r.fill = 5'(cnt + 1);
            end
         end
      end else begin
         r.cell_idx = it.rc;
         r.slot     = it.rs;
         if (it.rc >= usable_cells()) begin
            r.status = STATUS_OUTSIDE;
         end else begin
            cnt    = fill_cnt[it.rc];
            r.fill = cnt[4:0];
            if (it.rs >= cnt) begin
               r.status = STATUS_EMPTY;
            end else begin
               a = it.rc * N_SLOTS + it.rs;
               r.ox = pt_x[a];
               r.oy = pt_y[a];
               r.oz = pt_z[a];
            end
         end
      end
      return r;
   endfunction

   // coordinate that lands in cell c on one axis; random when none fits
   function automatic logic [31:0] pick_coord(input int unsigned c, input logic [31:0] org_v,
                                              input logic [31:0] inv_v);
      longint      o, iv, lo, hi, maxd, d;
      logic [63:0] r;
      o    = longint'($signed(org_v));
      iv   = inv_v;
      maxd = 64'sd2147483647 - o;
      if (iv == 0) begin
         lo = 0;
         hi = (c == 0) ? maxd : -1;
      end else begin
         lo = ((longint'(c) << 32) + iv - 1) / iv;
         hi = ((longint'(c + 1) << 32) + iv - 1) / iv - 1;
      end
      if (hi > maxd)
         hi = maxd;
      if (lo > hi)
         return $urandom;
      case ($urandom_range(0, 7))
         0: d = lo;
         1: d = hi;
         default: begin
            r = {$urandom, $urandom};
            d = lo + longint'(r % 64'(hi - lo + 1));
         end
      endcase
      return 32'(o + d);
   endfunction

   function automatic bin_req_type rand_noise(input logic cmd);
      bin_req_type it;
      it.cmd = cmd;
      it.px  = $urandom;
      it.py  = $urandom;
      it.pz  = $urandom;
      it.rc  = 12'($urandom);
      it.rs  = 4'($urandom);
      return it;
   endfunction

   function automatic bin_req_type gen_inside();
      bin_req_type it;
      int unsigned nx, ny, nz, total, lim, idx;
      it    = rand_noise(CMD_INSERT);
      nx    = grid_dims[23:16];
      ny    = grid_dims[15:8];
      nz    = grid_dims[7:0];
      total = nx * ny * nz;
      lim   = usable_cells();
      if (total < lim)
         lim = total;
      if (lim == 0)
         return it;
      // stack points on the last cell now and then so cells run full
      if (last_cell < lim && $urandom_range(0, 9) < 3)
         idx = last_cell;
      else
         idx = $urandom_range(0, lim - 1);
      it.pz = pick_coord(idx % nz, grid_org[2], grid_inv[2]);
      it.py = pick_coord((idx / nz) % ny, grid_org[1], grid_inv[1]);
      it.px = pick_coord(idx / (ny * nz), grid_org[0], grid_inv[0]);
      return it;
   endfunction

   function automatic bin_req_type gen_read();
      bin_req_type it;
      int unsigned c, cnt;
      it = rand_noise(CMD_READ);
      if (last_cell < usable_cells() && $urandom_range(0, 9) < 6)
         c = last_cell;
      else
         c = $urandom_range(0, usable_cells() - 1);
      it.rc = 12'(c);
      cnt   = fill_cnt[c];
      if (cnt > 0)
         it.rs = 4'($urandom_range(0, cnt - 1));
      return it;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      end
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ORIGIN_X:    grid_org[0] = val;
         CSR_ORIGIN_Y:    grid_org[1] = val;
         CSR_ORIGIN_Z:    grid_org[2] = val;
         CSR_INV_WIDTH_X: grid_inv[0] = val;
         CSR_INV_WIDTH_Y: grid_inv[1] = val;
         CSR_INV_WIDTH_Z: grid_inv[2] = val;
         CSR_GRID_DIMS:   grid_dims   = val[23:0];
         CSR_CELLS_USED:  cells_used  = val[12:0];
         default: ;
      endcase
   endtask

   task automatic program_grid(input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] oz, input logic [31:0] ix,
                               input logic [31:0] iy, input logic [31:0] iz,
                               input logic [23:0] dm, input logic [12:0] cu);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_ORIGIN_Z, oz);
      write_reg(CSR_INV_WIDTH_X, ix);
      write_reg(CSR_INV_WIDTH_Y, iy);
      write_reg(CSR_INV_WIDTH_Z, iz);
      write_reg(CSR_GRID_DIMS, {8'd0, dm});
      write_reg(CSR_CELLS_USED, {19'd0, cu});
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_bin(input bin_req_type it, input bit typed,
                           input bin_rsp_type typed_rsp);
      bin_rsp_type p;
      int          gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 14);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {it.rs, it.rc, it.pz, it.py, it.px};
      do @(posedge clock); while (!req_tready);
      p = predict_binning(it);
      pending_bins.push_back(typed ? typed_rsp : p);
      burst_left--;
   endtask

   // stop offering and let every outstanding transaction come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_bins.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_mon
      bin_rsp_type got;
      bin_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = rsp_tuser;
         got.cell_idx = rsp_tdata[11:0];
         got.slot     = rsp_tdata[15:12];
         got.fill     = rsp_tdata[20:16];
         got.ox       = rsp_tdata[52:21];
         got.oy       = rsp_tdata[84:53];
         got.oz       = rsp_tdata[116:85];
         if (pending_bins.size() == 0) begin
            errors++;
            $display("%0t unexpected response: expected none actual status %h cell %h",
                     $time, got.status, got.cell_idx);
         end else begin
            want = pending_bins.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("cell_index", 32'(want.cell_idx), 32'(got.cell_idx));
            check_field("slot_index", 32'(want.slot), 32'(got.slot));
            check_field("cell_fill", 32'(want.fill), 32'(got.fill));
            check_field("out_x", want.ox, got.ox);
            check_field("out_y", want.oy, got.oy);
            check_field("out_z", want.oz, got.oz);
         end
      end
   end

   // receiver: random stall modes, plus one long hold-off on request
   initial begin : rsp_sink
      int mode;
      int mode_left;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 7) != 0);
               default: rsp_tready <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   // rows typed with a result use the reset grid: one unit cell at the origin
   dir_row_type dir_tab [19] = '{
      '{CMD_INSERT, 32'h0, 32'h0, 32'h0, 12'h0, 4'h0, 1, 1'b1,
        STATUS_OK, 12'd0, 4'd0, 5'd1, 32'h0, 32'h0, 32'h0},
      '{CMD_READ, 32'h0, 32'h0, 32'h0, 12'h0, 4'h0, 1, 1'b1,
        STATUS_OK, 12'd0, 4'd0, 5'd1, 32'h0, 32'h0, 32'h0},
      '{CMD_INSERT, 32'h0000_FFFF, 32'h0000_8000, 32'h1, 12'h0, 4'h0, 1, 1'b1,
        STATUS_OK, 12'd0, 4'd1, 5'd2, 32'h0, 32'h0, 32'h0},
      '{CMD_READ, 32'h0, 32'h0, 32'h0, 12'h0, 4'h1, 1, 1'b1,
        STATUS_OK, 12'd0, 4'd1, 5'd2, 32'h0000_FFFF, 32'h0000_8000, 32'h1},
      '{CMD_INSERT, 32'h0001_0000, 32'h0, 32'h0, 12'h0, 4'h0, 1, 1'b1,
        STATUS_OUTSIDE, 12'd0, 4'd0, 5'd0, 32'h0, 32'h0, 32'h0},
      '{CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0, 12'h0, 4'h0, 1, 1'b1,
        STATUS_OUTSIDE, 12'd0, 4'd0, 5'd0, 32'h0, 32'h0, 32'h0},
      '{CMD_INSERT, 32'h7FFF_FFFF, 32'h0, 32'h0, 12'h0, 4'h0, 1, 1'b1,
        STATUS_OUTSIDE, 12'd0, 4'd0, 5'd0, 32'h0, 32'h0, 32'h0},
      '{CMD_INSERT, 32'h0, 32'h0, 32'h8000_0000, 12'h0, 4'h0, 1, 1'b1,
        STATUS_OUTSIDE, 12'd0, 4'd0, 5'd0, 32'h0, 32'h0, 32'h0},
      '{CMD_READ, 32'h0, 32'h0, 32'h0, 12'h1, 4'h0, 1, 1'b1,
        STATUS_OUTSIDE, 12'd1, 4'd0, 5'd0, 32'h0, 32'h0, 32'h0},
      '{CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 1, 1'b1,
        STATUS_OUTSIDE, 12'hFFF, 4'hF, 5'd0, 32'h0, 32'h0, 32'h0},
      '{CMD_READ, 32'h0, 32'h0, 32'h0, 12'h0, 4'h2, 1, 1'b1,
        STATUS_EMPTY, 12'd0, 4'd2, 5'd2, 32'h0, 32'h0, 32'h0},
      '{CMD_READ, 32'h0, 32'h0, 32'h0, 12'h0, 4'hF, 1, 1'b1,
        STATUS_EMPTY, 12'd0, 4'hF, 5'd2, 32'h0, 32'h0, 32'h0},
      '{CMD_INSERT, 32'h1234, 32'h5678, 32'h9ABC, 12'hFFF, 4'hF, 14, 1'b0,
        STATUS_OK, 12'd0, 4'd0, 5'd0, 32'h0, 32'h0, 32'h0},
      '{CMD_INSERT, 32'h0, 32'h0, 32'h0, 12'h0, 4'h0, 1, 1'b1,
        STATUS_FULL, 12'd0, 4'd0, 5'd16, 32'h0, 32'h0, 32'h0},
      '{CMD_READ, 32'h0, 32'h0, 32'h0, 12'h0, 4'hF, 1, 1'b1,
        STATUS_OK, 12'd0, 4'hF, 5'd16, 32'h1234, 32'h5678, 32'h9ABC},
      '{CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'h0, 4'h3, 1, 1'b0,
        STATUS_OK, 12'd0, 4'd0, 5'd0, 32'h0, 32'h0, 32'h0},
      '{CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'h0, 4'h0, 1, 1'b1,
        STATUS_OK, 12'd0, 4'd0, 5'd16, 32'h0, 32'h0, 32'h0},
      '{CMD_INSERT, 32'h8000, 32'h8000, 32'h8000, 12'hFFF, 4'hF, 1, 1'b1,
        STATUS_FULL, 12'd0, 4'd0, 5'd16, 32'h0, 32'h0, 32'h0},
      '{CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 12'h0, 4'h0, 1, 1'b1,
        STATUS_OUTSIDE, 12'd0, 4'd0, 5'd0, 32'h0, 32'h0, 32'h0}
   };

   initial begin : stim
      bin_req_type it;
      bin_rsp_type ex;
      int unsigned dx, dy, dz, prod;
      int          kind;

      for (int c = 0; c < 3; c++) begin
         grid_org[c] = 32'h0;
         grid_inv[c] = 32'h0001_0000;
      end
      grid_dims  = 24'd65793;
      cells_used = 13'd1;
      for (int c = 0; c < N_CELLS; c++)
         fill_cnt[c] = 5'd0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[r]) begin
         it = '{cmd: dir_tab[r].cmd, px: dir_tab[r].px, py: dir_tab[r].py,
                pz: dir_tab[r].pz, rc: dir_tab[r].rc, rs: dir_tab[r].rs};
         ex = '{status: dir_tab[r].st, cell_idx: dir_tab[r].cell_idx,
                slot: dir_tab[r].slot, fill: dir_tab[r].fill, ox: dir_tab[r].ox,
                oy: dir_tab[r].oy, oz: dir_tab[r].oz};
         for (int n = 0; n < dir_tab[r].reps; n++)
            send_bin(it, dir_tab[r].typed, ex);
      end

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         dx = $urandom_range(1, 16);
         dy = $urandom_range(1, 16);
         dz = $urandom_range(1, 16);
         prod = dx * dy * dz;
         case (ph)
            0: program_grid($urandom_range(0, 'h20000), $urandom_range(0, 'h20000),
                            $urandom_range(0, 'h20000), 32'h0001_0000, 32'h0001_0000,
                            32'h0001_0000, 24'h04_04_04, 13'd64);
            1: program_grid($urandom, $urandom, $urandom, $urandom_range(1 << 12, 1 << 24),
                            $urandom_range(1 << 12, 1 << 24), $urandom_range(1 << 12, 1 << 24),
                            {8'(dx), 8'(dy), 8'(dz)}, 13'(prod));
            // register extremes
            2: program_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
                            32'h1, 24'hFF_FFFF, 13'd4096);
            // usable cells beyond the memory
            3: program_grid($urandom, $urandom, $urandom, $urandom_range(1 << 10, 1 << 20),
                            $urandom_range(1 << 10, 1 << 20), $urandom_range(1 << 10, 1 << 20),
                            24'h10_10_10, 13'h1FFF);
            // zero cells along x
            4: program_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                            32'h0001_0000, 24'h00_04_04, 13'd16);
            5: program_grid($urandom, $urandom, $urandom, 32'h0001_0000, 32'h0002_0000,
                            32'h0000_8000, 24'h01_01_02, 13'd2);
            6: program_grid($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            24'($urandom), 13'($urandom_range(1, 8191)));
            default: program_grid($urandom, $urandom, $urandom, $urandom_range(1, 1 << 22),
                                  $urandom_range(1, 1 << 22), $urandom_range(1, 1 << 22),
                                  {8'(dx), 8'(dy), 8'(dz)},
                                  13'((prod > 1) ? prod / 2 : 1));
         endcase
         for (int n = 0; n < 175; n++) begin
            // long receiver hold-off while items keep coming
            if (ph == 1 && n == 10)
               hold_req = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 55)
               it = gen_inside();
            else if (kind < 65)
               it = rand_noise(CMD_INSERT);
            else if (kind < 90)
               it = gen_read();
            else
               it = rand_noise(CMD_READ);
            send_bin(it, 1'b0, ex);
         end
      end

      settle();
      if (errors == 0 && pending_bins.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### spatial_cell_list_binner.f
sv/scb_pkg.sv
sv/scb_axis.sv
sv/spatial_cell_list_binner.sv
dv/tb_top.sv
